>>> sv/mes_pkg.sv
// package for the midpoint ellipse stepper: widths, register indexes, region codes,
// microcode control word and the microprogram table
// no dependencies
`default_nettype none

package mes_pkg;

  localparam int AxisBitsDef  = 10;
  localparam int CoordBitsDef = 11;
  localparam int DecBits      = 40;
  localparam int CfgAddrBits  = 2;
  localparam int PcBits       = 6;

  typedef enum logic [CfgAddrBits-1:0] {
    CFG_CENTER_X   = 2'd0,
    CFG_CENTER_Y   = 2'd1,
    CFG_SEMI_MAJOR = 2'd2,
    CFG_SEMI_MINOR = 2'd3
  } cfg_addr_e;

  typedef enum logic [3:0] {
    RG_IDLE = 4'b0001,
    RG_ONE  = 4'b0010,
    RG_TWO  = 4'b0100,
    RG_DONE = 4'b1000
  } region_e;

  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_AA   = 3'd1,
    MUL_BB   = 3'd2,
    MUL_A2B  = 3'd3,
    MUL_B2A  = 3'd4,
    MUL_B2X  = 3'd5,
    MUL_A2Y  = 3'd6
  } mul_sel_e;

  typedef enum logic [1:0] {
    SQ_NONE = 2'd0,
    SQ_A2   = 2'd1,
    SQ_B2   = 2'd2
  } sq_ld_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_e;

  typedef enum logic [2:0] {
    TRM_P   = 3'd0,
    TRM_P2  = 3'd1,
    TRM_A2  = 3'd2,
    TRM_B2  = 3'd3,
    TRM_A2Q = 3'd4,
    TRM_B2Q = 3'd5
  } term_e;

  typedef enum logic [2:0] {
    POS_HOLD   = 3'd0,
    POS_START1 = 3'd1,
    POS_START2 = 3'd2,
    POS_XINC   = 3'd3,
    POS_XDEC   = 3'd4,
    POS_YINC   = 3'd5,
    POS_YDEC   = 3'd6
  } pos_op_e;

  typedef enum logic [2:0] {
    CND_NEVER   = 3'd0,
    CND_ALWAYS  = 3'd1,
    CND_RESTART = 3'd2,
    CND_REG1    = 3'd3,
    CND_REG2    = 3'd4,
    CND_DEC_POS = 3'd5,
    CND_T_GT_P  = 3'd6
  } cond_e;

  typedef struct packed {
    mul_sel_e          mul;
    sq_ld_e            sq;
    acc_op_e           acc;
    term_e             term;
    pos_op_e           pos;
    logic              ld_t;
    logic              fin_chk;
    logic              emit;
    logic [1:0]        emit_idx;
    cond_e             cond;
    logic [PcBits-1:0] target;
    logic              done;
  } ucode_t;

  typedef struct packed {
    logic reg_one;
    logic reg_two;
    logic dec_pos;
    logic t_gt_p;
  } dp_status_t;

  localparam ucode_t UwNop = '{
    mul: MUL_NONE, sq: SQ_NONE, acc: ACC_HOLD, term: TRM_P, pos: POS_HOLD,
    ld_t: 1'b0, fin_chk: 1'b0, emit: 1'b0, emit_idx: 2'd0, cond: CND_NEVER,
    target: '0, done: 1'b0
  };

  localparam logic [PcBits-1:0] PcRst  = 6'd6;
  localparam logic [PcBits-1:0] PcR1   = 6'd10;
  localparam logic [PcBits-1:0] PcR1e  = 6'd17;
  localparam logic [PcBits-1:0] PcQ    = 6'd21;
  localparam logic [PcBits-1:0] PcR2   = 6'd25;
  localparam logic [PcBits-1:0] PcR2e  = 6'd29;
  localparam logic [PcBits-1:0] PcChk  = 6'd33;
  localparam logic [PcBits-1:0] PcEmit = 6'd36;

  function automatic ucode_t mes_ucode(logic [PcBits-1:0] pc);
    ucode_t w;
    w = UwNop;
    case (pc)
      // squares of the axes, then dispatch
      6'd0: begin w.mul = MUL_AA; end
      6'd1: begin w.sq = SQ_A2; w.mul = MUL_BB; end
      6'd2: begin w.sq = SQ_B2; w.cond = CND_RESTART; w.target = PcRst; end
      6'd3: begin w.cond = CND_REG1; w.target = PcR1; end
      6'd4: begin w.cond = CND_REG2; w.target = PcR2; end
      6'd5: begin w.done = 1'b1; end
      // region 1 start
      6'd6: begin w.mul = MUL_A2B; end
      6'd7: begin w.acc = ACC_LOAD; w.term = TRM_B2; w.pos = POS_START1; end
      6'd8: begin w.acc = ACC_SUB; w.term = TRM_P; end
      6'd9: begin
        w.acc = ACC_ADD; w.term = TRM_A2Q; w.cond = CND_ALWAYS; w.target = PcEmit;
      end
      // region 1 step
      6'd10: begin w.mul = MUL_B2X; end
      6'd11: begin w.ld_t = 1'b1; w.mul = MUL_A2Y; end
      6'd12: begin w.cond = CND_T_GT_P; w.target = PcQ; end
      6'd13: begin w.pos = POS_XINC; w.cond = CND_DEC_POS; w.target = PcR1e; end
      6'd14: begin w.mul = MUL_B2X; end
      6'd15: begin w.acc = ACC_ADD; w.term = TRM_P2; end
      6'd16: begin
        w.acc = ACC_ADD; w.term = TRM_B2; w.cond = CND_ALWAYS; w.target = PcEmit;
      end
      6'd17: begin w.pos = POS_YDEC; w.mul = MUL_B2X; end
      6'd18: begin w.acc = ACC_ADD; w.term = TRM_P2; w.mul = MUL_A2Y; end
      6'd19: begin w.acc = ACC_SUB; w.term = TRM_P2; end
      6'd20: begin
        w.acc = ACC_ADD; w.term = TRM_B2; w.cond = CND_ALWAYS; w.target = PcEmit;
      end
      // region 2 start
      6'd21: begin w.pos = POS_START2; w.mul = MUL_B2A; end
      6'd22: begin w.acc = ACC_LOAD; w.term = TRM_A2; end
      6'd23: begin w.acc = ACC_SUB; w.term = TRM_P; end
      6'd24: begin
        w.acc = ACC_ADD; w.term = TRM_B2Q; w.cond = CND_ALWAYS; w.target = PcChk;
      end
      // region 2 step
      6'd25: begin w.pos = POS_YINC; w.cond = CND_DEC_POS; w.target = PcR2e; end
      6'd26: begin w.mul = MUL_A2Y; end
      6'd27: begin w.acc = ACC_ADD; w.term = TRM_P2; end
      6'd28: begin
        w.acc = ACC_ADD; w.term = TRM_A2; w.cond = CND_ALWAYS; w.target = PcChk;
      end
      6'd29: begin w.pos = POS_XDEC; w.mul = MUL_A2Y; end
      6'd30: begin w.acc = ACC_ADD; w.term = TRM_P2; w.mul = MUL_B2X; end
      6'd31: begin w.acc = ACC_SUB; w.term = TRM_P2; end
      6'd32: begin
        w.acc = ACC_ADD; w.term = TRM_A2; w.cond = CND_ALWAYS; w.target = PcChk;
      end
      // end of region 2 test
      6'd33: begin w.mul = MUL_B2X; end
      6'd34: begin w.ld_t = 1'b1; w.mul = MUL_A2Y; end
      6'd35: begin w.fin_chk = 1'b1; end
      // four symmetric pixels
      6'd36: begin w.emit = 1'b1; w.emit_idx = 2'd0; end
      6'd37: begin w.emit = 1'b1; w.emit_idx = 2'd1; end
      6'd38: begin w.emit = 1'b1; w.emit_idx = 2'd2; end
      6'd39: begin w.emit = 1'b1; w.emit_idx = 2'd3; w.done = 1'b1; end
      default: begin w.done = 1'b1; end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> sv/mes_datapath.sv
// datapath of the ellipse stepper: shared multiplier, squares, decision accumulator,
// offsets, region and pixel formation; driven by the microcode word, uses mes_pkg
`default_nettype none

module mes_datapath
  import mes_pkg::*;
#(
  parameter int AXIS_BITS  = AxisBitsDef,
  parameter int COORD_BITS = CoordBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ucode_t                       ctrl_i,
  input  wire logic [AXIS_BITS-1:0]         semi_major_i,
  input  wire logic [AXIS_BITS-1:0]         semi_minor_i,
  input  wire logic [COORD_BITS-1:0]        center_x_i,
  input  wire logic [COORD_BITS-1:0]        center_y_i,
  output dp_status_t                        stat_o,
  output logic signed [COORD_BITS+1:0]      pixel_x_o,
  output logic signed [COORD_BITS+1:0]      pixel_y_o
);

  localparam int OffBits  = AXIS_BITS + 1;
  localparam int SqBits   = 2 * AXIS_BITS;
  localparam int ProdBits = SqBits + 1 + OffBits;
  localparam int PixBits  = COORD_BITS + 2;
  localparam logic [OffBits-1:0] OffOne = {{(OffBits-1){1'b0}}, 1'b1};

  logic [SqBits-1:0]          a2_q, a2_d, b2_q, b2_d;
  logic signed [ProdBits-1:0] p_q, p_d, t_q, t_d;
  logic signed [DecBits-1:0]  dec_q, dec_d;
  logic signed [OffBits-1:0]  x_q, x_d, y_q, y_d;
  region_e                    region_q, region_d;

  logic signed [SqBits:0]     mul_a;
  logic signed [OffBits-1:0]  mul_b;
  logic signed [ProdBits-1:0] prod;
  logic signed [SqBits:0]     a_w, b_w, a2_w, b2_w;
  logic signed [OffBits-1:0]  a_n, b_n;
  logic signed [DecBits-1:0]  p_ext, term;
  logic                       t_gt_p;

  assign a_w  = signed'({{(SqBits+1-AXIS_BITS){1'b0}}, semi_major_i});
  assign b_w  = signed'({{(SqBits+1-AXIS_BITS){1'b0}}, semi_minor_i});
  assign a2_w = signed'({1'b0, a2_q});
  assign b2_w = signed'({1'b0, b2_q});
  assign a_n  = signed'({1'b0, semi_major_i});
  assign b_n  = signed'({1'b0, semi_minor_i});

  always_comb begin
    case (ctrl_i.mul)
      MUL_AA: begin
        mul_a = a_w;
        mul_b = a_n;
      end
      MUL_BB: begin
        mul_a = b_w;
        mul_b = b_n;
      end
      MUL_A2B: begin
        mul_a = a2_w;
        mul_b = b_n;
      end
      MUL_B2A: begin
        mul_a = b2_w;
        mul_b = a_n;
      end
      MUL_B2X: begin
        mul_a = b2_w;
        mul_b = x_q;
      end
      MUL_A2Y: begin
        mul_a = a2_w;
        mul_b = y_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod  = ProdBits'(mul_a) * ProdBits'(mul_b);
  assign p_ext = DecBits'(p_q);

  always_comb begin
    case (ctrl_i.term)
      TRM_P:   term = p_ext;
      TRM_P2:  term = {p_ext[DecBits-2:0], 1'b0};
      TRM_A2:  term = signed'(DecBits'(a2_q));
      TRM_B2:  term = signed'(DecBits'(b2_q));
      TRM_A2Q: term = signed'(DecBits'(a2_q >> 2));
      TRM_B2Q: term = signed'(DecBits'(b2_q >> 2));
      default: term = '0;
    endcase
  end

  assign t_gt_p = t_q > p_q;

  always_comb begin
    p_d      = p_q;
    t_d      = t_q;
    a2_d     = a2_q;
    b2_d     = b2_q;
    dec_d    = dec_q;
    x_d      = x_q;
    y_d      = y_q;
    region_d = region_q;
    if (ctrl_i.mul != MUL_NONE) begin
      p_d = prod;
    end
    if (ctrl_i.ld_t) begin
      t_d = p_q;
    end
    case (ctrl_i.sq)
      SQ_A2:   a2_d = p_q[SqBits-1:0];
      SQ_B2:   b2_d = p_q[SqBits-1:0];
      default: ;
    endcase
    case (ctrl_i.acc)
      ACC_LOAD: dec_d = term;
      ACC_ADD:  dec_d = dec_q + term;
      ACC_SUB:  dec_d = dec_q - term;
      default:  ;
    endcase
    case (ctrl_i.pos)
      POS_START1: begin
        x_d      = '0;
        y_d      = signed'({1'b0, semi_minor_i});
        region_d = RG_ONE;
      end
      POS_START2: begin
        x_d      = signed'({1'b0, semi_major_i});
        y_d      = '0;
        region_d = RG_TWO;
      end
      POS_XINC: x_d = x_q + OffOne;
      POS_XDEC: x_d = x_q - OffOne;
      POS_YINC: y_d = y_q + OffOne;
      POS_YDEC: y_d = y_q - OffOne;
      default:  ;
    endcase
    if (ctrl_i.fin_chk && !t_gt_p) begin
      region_d = RG_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q    <= '0;
      x_q      <= '0;
      y_q      <= '0;
      region_q <= RG_IDLE;
    end else begin
      dec_q    <= dec_d;
      x_q      <= x_d;
      y_q      <= y_d;
      region_q <= region_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q  <= p_d;
    t_q  <= t_d;
    a2_q <= a2_d;
    b2_q <= b2_d;
  end

  assign stat_o.reg_one = (region_q == RG_ONE);
  assign stat_o.reg_two = (region_q == RG_TWO);
  assign stat_o.dec_pos = !dec_q[DecBits-1] && (dec_q != '0);
  assign stat_o.t_gt_p  = t_gt_p;

  // pixel order: (+x,+y) (-x,+y) (-x,-y) (+x,-y)
  logic                      neg_x, neg_y;
  logic signed [PixBits-1:0] cx_ext, cy_ext, x_ext, y_ext;

  assign neg_x  = (ctrl_i.emit_idx == 2'd1) || (ctrl_i.emit_idx == 2'd2);
  assign neg_y  = ctrl_i.emit_idx[1];
  assign cx_ext = signed'(PixBits'({1'b0, center_x_i}));
  assign cy_ext = signed'(PixBits'({1'b0, center_y_i}));
  assign x_ext  = PixBits'(x_q);
  assign y_ext  = PixBits'(y_q);

  assign pixel_x_o = neg_x ? (cx_ext - x_ext) : (cx_ext + x_ext);
  assign pixel_y_o = neg_y ? (cy_ext - y_ext) : (cy_ext + y_ext);

endmodule

`default_nettype wire

>>> sv/midpoint_ellipse_stepper_core.sv
// top level of the midpoint ellipse stepper: configuration registers, microcode
// sequencer and output register; uses mes_pkg and mes_datapath
//
// usage: write center_x, center_y, semi_major, semi_minor on the cfg channel
// (index 0..3) while the block is idle. each request on the input channel
// carries restart: 1 plots the start point (0,b) of a new ellipse, 0 makes one
// step. a plotting request gives four pixel results in order (+x,+y) (-x,+y)
// (-x,-y) (+x,-y), last set on the fourth and finished set on all four when the
// step ends region 2. a step while idle or after the ellipse is done gives none.
// each request runs a microprogram path that shares one multiplier: restart,
// region 1 step, region switch, region 2 step or no-result step. the input is
// taken only while no program runs, so a new request is accepted only after the
// program of the last one has ended.
// results leave through a one-entry output register; while the receiver stalls,
// the sequencer waits on its pixel step and the next request is held off.
// reset clears configuration, position, decision and region (idle) and empties
// the output register.
`default_nettype none

module midpoint_ellipse_stepper_core
  import mes_pkg::*;
#(
  parameter int AXIS_BITS  = AxisBitsDef,
  parameter int COORD_BITS = CoordBitsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [CfgAddrBits-1:0]     cfg_addr_i,
  input  wire logic [((COORD_BITS > AXIS_BITS) ? COORD_BITS : AXIS_BITS)-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       restart_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [COORD_BITS+1:0]    pixel_x_o,
  output logic signed [COORD_BITS+1:0]    pixel_y_o,
  output logic                            last_o,
  output logic                            finished_o
);

  localparam int PixBits = COORD_BITS + 2;

  logic [COORD_BITS-1:0] cx_q, cy_q;
  logic [AXIS_BITS-1:0]  a_q, b_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      a_q  <= '0;
      b_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_e'(cfg_addr_i))
        CFG_CENTER_X:   cx_q <= cfg_data_i[COORD_BITS-1:0];
        CFG_CENTER_Y:   cy_q <= cfg_data_i[COORD_BITS-1:0];
        CFG_SEMI_MAJOR: a_q  <= cfg_data_i[AXIS_BITS-1:0];
        CFG_SEMI_MINOR: b_q  <= cfg_data_i[AXIS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  logic              busy_q, busy_d;
  logic [PcBits-1:0] pc_q, pc_d;
  logic              restart_q, restart_d;
  logic              fin_q, fin_d;
  ucode_t            uw, ctrl;
  dp_status_t        stat;
  logic              stall, take;

  logic signed [PixBits-1:0] dp_px, dp_py;
  logic signed [PixBits-1:0] px_q, py_q;
  logic                      out_valid_q, out_valid_d, last_q, finished_q;
  logic                      load_out;

  assign uw    = mes_ucode(pc_q);
  assign ctrl  = busy_q ? uw : UwNop;
  assign stall = uw.emit && out_valid_q && !out_ready_i;

  always_comb begin
    case (uw.cond)
      CND_NEVER:   take = 1'b0;
      CND_ALWAYS:  take = 1'b1;
      CND_RESTART: take = restart_q;
      CND_REG1:    take = stat.reg_one;
      CND_REG2:    take = stat.reg_two;
      CND_DEC_POS: take = stat.dec_pos;
      CND_T_GT_P:  take = stat.t_gt_p;
      default:     take = 1'b0;
    endcase
  end

  assign in_ready_o = !busy_q;

  always_comb begin
    busy_d    = busy_q;
    pc_d      = pc_q;
    restart_d = restart_q;
    fin_d     = fin_q;
    if (!busy_q) begin
      if (in_valid_i) begin
        busy_d    = 1'b1;
        pc_d      = '0;
        restart_d = restart_i;
        fin_d     = 1'b0;
      end
    end else if (!stall) begin
      if (uw.done) begin
        busy_d = 1'b0;
      end else if (take) begin
        pc_d = uw.target;
      end else begin
        pc_d = pc_q + 1'b1;
      end
      if (uw.fin_chk) begin
        fin_d = !stat.t_gt_p;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      pc_q      <= '0;
      restart_q <= 1'b0;
      fin_q     <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      pc_q      <= pc_d;
      restart_q <= restart_d;
      fin_q     <= fin_d;
    end
  end

  mes_datapath #(
    .AXIS_BITS  (AXIS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .semi_major_i (a_q),
    .semi_minor_i (b_q),
    .center_x_i   (cx_q),
    .center_y_i   (cy_q),
    .stat_o       (stat),
    .pixel_x_o    (dp_px),
    .pixel_y_o    (dp_py)
  );

  // output register
  assign load_out = busy_q && uw.emit && !stall;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      px_q       <= dp_px;
      py_q       <= dp_py;
      last_q     <= (uw.emit_idx == 2'd3);
      finished_q <= fin_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = px_q;
  assign pixel_y_o   = py_q;
  assign last_o      = last_q;
  assign finished_o  = finished_q;

  // a pixel step waits while the output register is held
  a_stall_holds_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && stall) |=> $stable(pc_q))
    else $error("sequencer moved while output stalled");

  // the fourth pixel ends the program and carries last
  a_last_ends_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && uw.emit && uw.done && !stall) |=> (!busy_q && out_valid_o && last_o))
    else $error("last pixel did not end the program");

  // an accepted request starts the program at its first step
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (busy_q && (pc_q == '0)))
    else $error("request did not start the microprogram");

endmodule

`default_nettype wire

>>> bench/tb.sv
// self-checking bench for midpoint_ellipse_stepper_core: drives geometry writes and
// restart/step requests, predicts the four symmetric pixels of each step and checks them
// depends on mes_pkg and midpoint_ellipse_stepper_core
`default_nettype none

module tb;
  import mes_pkg::*;

  localparam int PixW  = CoordBitsDef + 2;
  localparam int OffW  = AxisBitsDef + 1;
  localparam int CfgW  = (CoordBitsDef > AxisBitsDef) ? CoordBitsDef : AxisBitsDef;
  localparam int Limit = 800000;
  localparam int Drain = 40;
  localparam int Items = 320;

  typedef struct packed {
    logic [PixW-1:0] x;
    logic [PixW-1:0] y;
    logic            last;
    logic            fin;
  } pixel_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  cfg_addr_e         cfg_addr = CFG_CENTER_X;
  logic [CfgW-1:0]   cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              restart = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [PixW-1:0]   pixel_x;
  logic [PixW-1:0]   pixel_y;
  logic              last;
  logic              finished;

  pixel_t pixel_q[$];
  int     faults = 0;
  int     cycles = 0;
  int     sent = 0;
  int     burst_left = 0;
  bit     sending = 1'b0;

  // geometry and tracer state of the predictor
  longint  cx = 0, cy = 0, sa = 0, sb = 0;
  longint  ox = 0, oy = 0, dec = 0;
  region_e rgn = RG_IDLE;

  logic [15:0] stall_pat = 16'hffff;
  logic [5:0]  stall_tick = '0;

  midpoint_ellipse_stepper_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_addr_i  (cfg_addr),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .restart_i   (restart),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .pixel_x_o   (pixel_x),
    .pixel_y_o   (pixel_y),
    .last_o      (last),
    .finished_o  (finished)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_tick == 6'd0) begin
      stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom()) | 16'h1);
    end
    stall_tick <= stall_tick - 6'd1;
    out_ready <= stall_pat[stall_tick[3:0]];
  end

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        $display("%0t unexpected pixel x=%0d y=%0d last=%0b finished=%0b", $time,
                 $signed(pixel_x), $signed(pixel_y), last, finished);
        faults++;
      end else begin
        want = pixel_q.pop_front();
        if (pixel_x !== want.x || pixel_y !== want.y || last !== want.last ||
            finished !== want.fin) begin
          $display("%0t mismatch: exp x=%0d y=%0d l=%0b f=%0b got x=%0d y=%0d l=%0b f=%0b",
                   $time, $signed(want.x), $signed(want.y), want.last, want.fin,
                   $signed(pixel_x), $signed(pixel_y), last, finished);
          faults++;
        end
      end
    end
  end

  function automatic longint wrap_to(longint v, int bits);
    longint t;
    t = v <<< (64 - bits);
    return t >>> (64 - bits);
  endfunction

  task automatic push_pixels(bit fin);
    pixel_t p;
    longint px, py;
    for (int k = 0; k < 4; k++) begin
      px = (k == 0 || k == 3) ? cx + ox : cx - ox;
      py = (k < 2) ? cy + oy : cy - oy;
      p.x = px[PixW-1:0];
      p.y = py[PixW-1:0];
      p.last = (k == 3);
      p.fin = fin;
      pixel_q.push_back(p);
    end
  endtask

  task automatic ellipse_step(bit rs);
    longint a2, b2;
    bit fin;
    a2 = sa * sa;
    b2 = sb * sb;
    fin = 1'b0;
    if (rs) begin
      rgn = RG_ONE;
      ox = 0;
      oy = wrap_to(sb, OffW);
      dec = wrap_to(b2 - a2 * sb + a2 / 4, DecBits);
      push_pixels(1'b0);
    end else if (rgn == RG_ONE) begin
      if (b2 * ox <= a2 * oy) begin
        ox = wrap_to(ox + 1, OffW);
        if (dec <= 0) begin
          dec = wrap_to(dec + 2 * b2 * ox + b2, DecBits);
        end else begin
          oy = wrap_to(oy - 1, OffW);
          dec = wrap_to(dec + 2 * b2 * ox + b2 - 2 * a2 * oy, DecBits);
        end
      end else begin
        rgn = RG_TWO;
        ox = wrap_to(sa, OffW);
        oy = 0;
        dec = wrap_to(a2 - b2 * sa + b2 / 4, DecBits);
        if (!(b2 * ox > a2 * oy)) begin
          fin = 1'b1;
          rgn = RG_DONE;
        end
      end
      push_pixels(fin);
    end else if (rgn == RG_TWO) begin
      oy = wrap_to(oy + 1, OffW);
      if (dec <= 0) begin
        dec = wrap_to(dec + 2 * a2 * oy + a2, DecBits);
      end else begin
        ox = wrap_to(ox - 1, OffW);
        dec = wrap_to(dec + 2 * a2 * oy + a2 - 2 * b2 * ox, DecBits);
      end
      if (!(b2 * ox > a2 * oy)) begin
        fin = 1'b1;
        rgn = RG_DONE;
      end
      push_pixels(fin);
    end
  endtask

  task automatic send_request(bit rs);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if (sending && $urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        sending = 1'b0;
      end
    end
    if (!sending) repeat ($urandom_range(1, 5)) @(posedge clk);
    in_valid <= 1'b1;
    restart <= rs;
    sending = 1'b1;
    do @(posedge clk); while (!in_ready);
    ellipse_step(rs);
    sent++;
    burst_left--;
  endtask

  task automatic pause_requests();
    if (sending) begin
      in_valid <= 1'b0;
      sending = 1'b0;
    end
    burst_left = 0;
  endtask

  // stop sending, let every pixel come back, then give a step with no pixels time to end
  task automatic settle();
    pause_requests();
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic write_reg(cfg_addr_e idx, int val);
    logic [CfgW-1:0] d;
    d = val[CfgW-1:0];
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CENTER_X:   cx = d[CoordBitsDef-1:0];
      CFG_CENTER_Y:   cy = d[CoordBitsDef-1:0];
      CFG_SEMI_MAJOR: sa = d[AxisBitsDef-1:0];
      CFG_SEMI_MINOR: sb = d[AxisBitsDef-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
  endtask

  // the unused upper data bit of the axis writes gets a random value
  task automatic load_geometry(int x, int y, int a, int b);
    write_reg(CFG_CENTER_X, x);
    write_reg(CFG_CENTER_Y, y);
    write_reg(CFG_SEMI_MAJOR, a | ($urandom_range(0, 1) << AxisBitsDef));
    write_reg(CFG_SEMI_MINOR, b | ($urandom_range(0, 1) << AxisBitsDef));
    end_writes();
  endtask

  task automatic test_idle_steps();
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
  endtask

  task automatic test_extreme_axes();
    settle();
    load_geometry(2047, 2047, 1023, 1023);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    settle();
    load_geometry(0, 0, 1023, 1023);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
  endtask

  // flat ellipses: with a = 0, region 2 fails its test on its first point
  task automatic test_degenerate_axes();
    settle();
    load_geometry(100, 200, 0, 1023);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    settle();
    load_geometry(1500, 9, 1023, 0);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
  endtask

  task automatic test_mid_ellipse_update();
    int n;
    settle();
    load_geometry(300, 400, 6, 4);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    settle();
    write_reg(CFG_SEMI_MINOR, 9);
    write_reg(CFG_CENTER_X, 50);
    end_writes();
    n = 0;
    while (rgn != RG_DONE && n < 60) begin
      send_request(1'b0);
      n++;
    end
    settle();
    load_geometry(700, 20, 5, 7);
    send_request(1'b1);
    n = 0;
    while (rgn == RG_ONE && n < 40) begin
      send_request(1'b0);
      n++;
    end
    send_request(1'b0);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
  endtask

  // both axes zero: region 1 keeps stepping x and never ends
  task automatic test_zero_axes();
    settle();
    load_geometry(1023, 5, 0, 0);
    send_request(1'b1);
    repeat (20) send_request(1'b0);
  endtask

  task automatic test_random_ellipses();
    int kind, n, cut, a, b;
    while (sent < Items) begin
      kind = $urandom_range(0, 9);
      settle();
      if (kind == 0) begin
        a = $urandom_range(0, 1023);
        b = $urandom_range(0, 1023);
      end else begin
        a = $urandom_range(0, 12);
        b = $urandom_range(0, 12);
      end
      load_geometry($urandom_range(0, 2047), $urandom_range(0, 2047), a, b);
      if (kind == 0) begin
        send_request(1'b1);
        repeat ($urandom_range(1, 20)) send_request(1'b0);
      end else if (kind == 1) begin
        repeat ($urandom_range(1, 15)) send_request($urandom_range(0, 3) == 0);
      end else begin
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : -1;
        send_request(1'b1);
        n = 0;
        while (rgn != RG_DONE && n < 80 && sent < Items) begin
          send_request(n == cut);
          n++;
        end
        repeat ($urandom_range(0, 2)) send_request(1'b0);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_steps();
    test_extreme_axes();
    test_degenerate_axes();
    test_mid_ellipse_update();
    test_zero_axes();
    test_random_ellipses();
    pause_requests();
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
    if (faults == 0 && pixel_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
